[rtl/core/ordered_array_list_engine_core_assert.svh]
// Assertion macros for the ordered array list engine core.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OALE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("oale: same-cycle check failed");
`define OALE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("oale: next-cycle check failed");
`else
`define OALE_ASSERT_NOW(lbl, ante, cons)
`define OALE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/oale_pkg.sv]
// Shared types and constants for the ordered array list engine core.
// No dependencies.
package oale_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 11;
    localparam int IDX_W = 10;
    localparam int LEN_W = 11;
    localparam int CAP_W = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_FIND   = 3'd1,
        OP_PRIOR  = 3'd2,
        OP_NEXT   = 3'd3,
        OP_INSERT = 3'd4,
        OP_DELETE = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RDATA,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic strobe;
        logic ok;
    } t_res;

endpackage

[rtl/core/oale_ram.sv]
// Entry store: one write port, one read port with registered read data.
// No dependencies.
module oale_ram #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_WIDTH-1:0]    i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/oale_ctrl.sv]
// Sequencer of the list engine: decodes a request, then reads, scans or
// shifts the entry store one entry per cycle. Uses oale_pkg and the assert header.
`include "ordered_array_list_engine_core_assert.svh"

module oale_ctrl #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [oale_pkg::OP_W-1:0]        i_opcode,
    input  logic [oale_pkg::POS_W-1:0]       i_position,
    input  logic [DATA_WIDTH-1:0]            i_value,
    input  logic [oale_pkg::CAP_W-1:0]       i_cap,
    output logic                             o_we,
    output logic [$clog2(DEPTH)-1:0]         o_waddr,
    output logic [DATA_WIDTH-1:0]            o_wdata,
    output logic                             o_re,
    output logic [$clog2(DEPTH)-1:0]         o_raddr,
    input  logic [DATA_WIDTH-1:0]            i_rdata,
    output oale_pkg::t_res                   o_res,
    output logic [DATA_WIDTH-1:0]            o_data,
    output logic [$clog2(DEPTH)-1:0]         o_idx,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W) + 1;

    oale_pkg::t_state r_state, n_state;

    logic [oale_pkg::OP_W-1:0]  r_op, n_op;
    logic [oale_pkg::POS_W-1:0] r_pos, n_pos;
    logic [DATA_WIDTH-1:0]      r_val, n_val;
    logic [AW-1:0]              r_ptr, n_ptr;
    logic [AW-1:0]              r_wa, n_wa;
    logic [CW-1:0]              r_rem, n_rem;
    logic                       r_pend, n_pend;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_done, n_done;
    logic                       r_ok, n_ok;
    logic [DATA_WIDTH-1:0]      r_data, n_data;
    logic [AW-1:0]              r_idx, n_idx;

    logic [XW-1:0] pos_x, cnt_x, cap_x, dep_x;
    logic [XW-1:0] pm1_x, pp1_x, pp2_x, cm1_x, diff_x, dm1_x;
    logic          is_ins;

    assign pos_x  = XW'(r_pos);
    assign cnt_x  = XW'(r_count);
    assign cap_x  = XW'(i_cap);
    assign dep_x  = XW'(DEPTH);
    assign pm1_x  = pos_x - XW'(1);
    assign pp1_x  = pos_x + XW'(1);
    assign pp2_x  = pos_x + XW'(2);
    assign cm1_x  = cnt_x - XW'(1);
    assign diff_x = cnt_x - pos_x;
    assign dm1_x  = diff_x - XW'(1);
    assign is_ins = (r_op == oale_pkg::OP_INSERT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oale_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_pend  <= n_pend;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_op   <= n_op;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_ptr  <= n_ptr;
        r_wa   <= n_wa;
        r_rem  <= n_rem;
        r_ok   <= n_ok;
        r_data <= n_data;
        r_idx  <= n_idx;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_pos   = r_pos;
        n_val   = r_val;
        n_ptr   = r_ptr;
        n_wa    = r_wa;
        n_rem   = r_rem;
        n_pend  = r_pend;
        n_count = r_count;
        n_done  = 1'b0;
        n_ok    = r_ok;
        n_data  = r_data;
        n_idx   = r_idx;
        o_we    = 1'b0;
        o_waddr = r_wa;
        o_wdata = i_rdata;
        o_re    = 1'b0;
        o_raddr = r_ptr;

        case (r_state)
            oale_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_op    = i_opcode;
                    n_pos   = i_position;
                    n_val   = i_value;
                    n_state = oale_pkg::ST_DECODE;
                end
            end

            oale_pkg::ST_DECODE: begin
                n_done  = 1'b1;
                n_ok    = 1'b0;
                n_data  = '0;
                n_idx   = '0;
                n_pend  = 1'b0;
                n_state = oale_pkg::ST_IDLE;
                case (oale_pkg::t_op'(r_op))
                    oale_pkg::OP_GET: begin
                        if (pos_x < cnt_x) begin
                            o_re    = 1'b1;
                            o_raddr = pos_x[AW-1:0];
                            n_wa    = pos_x[AW-1:0];
                            n_done  = 1'b0;
                            n_state = oale_pkg::ST_RDATA;
                        end
                    end
                    oale_pkg::OP_PRIOR: begin
                        if (pos_x != '0 && pos_x < cnt_x) begin
                            o_re    = 1'b1;
                            o_raddr = pm1_x[AW-1:0];
                            n_wa    = pm1_x[AW-1:0];
                            n_done  = 1'b0;
                            n_state = oale_pkg::ST_RDATA;
                        end
                    end
                    oale_pkg::OP_NEXT: begin
                        if (pp2_x <= cnt_x) begin
                            o_re    = 1'b1;
                            o_raddr = pp1_x[AW-1:0];
                            n_wa    = pp1_x[AW-1:0];
                            n_done  = 1'b0;
                            n_state = oale_pkg::ST_RDATA;
                        end
                    end
                    oale_pkg::OP_FIND: begin
                        if (pos_x < cnt_x) begin
                            n_ptr   = pos_x[AW-1:0];
                            n_rem   = diff_x[CW-1:0];
                            n_done  = 1'b0;
                            n_state = oale_pkg::ST_SCAN;
                        end
                    end
                    oale_pkg::OP_INSERT: begin
                        if (pos_x <= cnt_x && cnt_x < cap_x && cnt_x < dep_x) begin
                            n_ptr   = cm1_x[AW-1:0];
                            n_rem   = diff_x[CW-1:0];
                            n_done  = 1'b0;
                            n_state = oale_pkg::ST_SHIFT;
                        end
                    end
                    oale_pkg::OP_DELETE: begin
                        if (pos_x < cnt_x) begin
                            n_ptr   = pp1_x[AW-1:0];
                            n_rem   = dm1_x[CW-1:0];
                            n_done  = 1'b0;
                            n_state = oale_pkg::ST_SHIFT;
                        end
                    end
                    oale_pkg::OP_CLEAR: begin
                        n_count = '0;
                        n_ok    = 1'b1;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end

            oale_pkg::ST_RDATA: begin
                n_done  = 1'b1;
                n_ok    = 1'b1;
                n_data  = i_rdata;
                n_idx   = r_wa;
                n_state = oale_pkg::ST_IDLE;
            end

            oale_pkg::ST_SCAN: begin
                if (r_pend && i_rdata == r_val) begin
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_idx   = r_wa;
                    n_pend  = 1'b0;
                    n_state = oale_pkg::ST_IDLE;
                end else if (r_rem != '0) begin
                    o_re    = 1'b1;
                    o_raddr = r_ptr;
                    n_wa    = r_ptr;
                    n_ptr   = r_ptr + AW'(1);
                    n_rem   = r_rem - CW'(1);
                    n_pend  = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_done  = 1'b1;
                    n_ok    = 1'b0;
                    n_state = oale_pkg::ST_IDLE;
                end
            end

            oale_pkg::ST_SHIFT: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_wa;
                    o_wdata = i_rdata;
                end
                if (r_rem != '0) begin
                    o_re    = 1'b1;
                    o_raddr = r_ptr;
                    n_wa    = is_ins ? r_ptr + AW'(1) : r_ptr - AW'(1);
                    n_ptr   = is_ins ? r_ptr - AW'(1) : r_ptr + AW'(1);
                    n_rem   = r_rem - CW'(1);
                    n_pend  = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    if (is_ins) begin
                        o_we    = 1'b1;
                        o_waddr = pos_x[AW-1:0];
                        o_wdata = r_val;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_idx   = pos_x[AW-1:0];
                    n_state = oale_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = oale_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != oale_pkg::ST_IDLE);
    assign o_res.strobe = r_done;
    assign o_res.ok     = r_ok;
    assign o_data      = r_data;
    assign o_idx       = r_idx;
    assign o_count     = r_count;

    `OALE_ASSERT_NOW(a_count_max, 1'b1, r_count <= CW'(DEPTH))
    `OALE_ASSERT_NOW(a_done_idle, r_done, r_state == oale_pkg::ST_IDLE)
    `OALE_ASSERT_NOW(a_write_shift, o_we, r_state == oale_pkg::ST_SHIFT)
    `OALE_ASSERT_NOW(a_count_on_done, $past(i_rst_n) && (r_count != $past(r_count)), r_done)
    `OALE_ASSERT_NEXT(a_accept_decode, !o_busy && i_start, r_state == oale_pkg::ST_DECODE)

endmodule

[rtl/core/ordered_array_list_engine_core.sv]
// Top level of the ordered array list engine: capacity register, sequencer
// and entry store. Depends on oale_pkg, oale_ctrl and oale_ram.
//
// Channel  | Ports                                         | Handshake
// request  | i_opcode, i_position, i_value                 | start & !busy
// result   | o_ok, o_data_out, o_index_out, o_length_out,  | o_res_valid, one cycle
//          | o_empty_res                                   |
// config   | i_cap_wdata                                   | i_cap_we
//
// Get, prior and next read one entry; clear and rejected requests end in decode.
// Find scans from position to the end of the list and stops at the first match;
// insert and delete shift the entries from position on, one entry per cycle
// through the single store port pair.
// Reset empties the list and sets capacity to 1024; store contents are kept.
// busy is high from accept until the cycle o_res_valid is shown; results cannot be held off.
module ordered_array_list_engine_core #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [oale_pkg::OP_W-1:0]         i_opcode,
    input  logic [oale_pkg::POS_W-1:0]        i_position,
    input  logic signed [DATA_WIDTH-1:0]      i_value,
    input  logic                              i_cap_we,
    input  logic [oale_pkg::CAP_W-1:0]        i_cap_wdata,
    output logic                              o_res_valid,
    output logic                              o_ok,
    output logic signed [DATA_WIDTH-1:0]      o_data_out,
    output logic [oale_pkg::IDX_W-1:0]        o_index_out,
    output logic [oale_pkg::LEN_W-1:0]        o_length_out,
    output logic                              o_empty_res
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IXW = (AW > oale_pkg::IDX_W) ? AW : oale_pkg::IDX_W;
    localparam int LXW = (CW > oale_pkg::LEN_W) ? CW : oale_pkg::LEN_W;

    logic [oale_pkg::CAP_W-1:0] r_cap;

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;
    oale_pkg::t_res        res;
    logic [DATA_WIDTH-1:0] res_data;
    logic [AW-1:0]         res_idx;
    logic [CW-1:0]         count;
    logic [IXW-1:0]        idx_x;
    logic [LXW-1:0]        len_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= oale_pkg::CAP_RESET;
        end else if (i_cap_we) begin
            r_cap <= i_cap_wdata;
        end
    end

    oale_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_opcode   (i_opcode),
        .i_position (i_position),
        .i_value    (i_value),
        .i_cap      (r_cap),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_res      (res),
        .o_data     (res_data),
        .o_idx      (res_idx),
        .o_count    (count)
    );

    oale_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign idx_x = IXW'(res_idx);
    assign len_x = LXW'(count);

    assign o_res_valid  = res.strobe;
    assign o_ok         = res.ok;
    assign o_data_out   = res_data;
    assign o_index_out  = idx_x[oale_pkg::IDX_W-1:0];
    assign o_length_out = len_x[oale_pkg::LEN_W-1:0];
    assign o_empty_res  = (count == '0);

endmodule
